>>> src/assert_macros.svh
// Assertion macros for the checker file.
// No dependencies; pulled in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HTS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HTS_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/hts_pkg.sv
// Shared constants and codes for the heightmap triangle sampler.
// No dependencies.
package hts_pkg;

	localparam int GRID_SIDE   = 128;
	localparam int STORE_DEPTH = 16384;

	localparam int ADDR_W  = $clog2(STORE_DEPTH);
	localparam int COORD_W = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
	localparam int VERTS_W = $clog2(GRID_SIDE + 1);
	localparam int LIN_W   = 2 * COORD_W;

	localparam int IDX_W     = 14;
	localparam int HGT_W     = 16;
	localparam int Q_W       = 32;
	localparam int FRAC_W    = 16;
	localparam int WGT_W     = FRAC_W + 1;
	localparam int VCFG_W    = 8;
	localparam int CFG_IDX_W = 3;

	localparam logic [HGT_W-1:0] UNDEF_CODE = 16'h8000;
	localparam logic [WGT_W-1:0] ONE_Q16    = 17'h10000;
	localparam logic [Q_W-1:0]   RES_UNDEF  = 32'h8000_0000;
	localparam logic [Q_W-1:0]   Q_MAX      = 32'h7FFF_FFFF;
	localparam logic [Q_W-1:0]   Q_MIN      = 32'h8000_0000;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORIGIN_X,
		CFG_ORIGIN_Z,
		CFG_INV_SPACING_X,
		CFG_INV_SPACING_Z,
		CFG_VERTS_X,
		CFG_VERTS_Z,
		CFG_HEIGHT_SCALE,
		CFG_HEIGHT_OFFSET
	} cfg_reg_t;

endpackage

>>> src/heightmap_triangle_sampler.sv
// Heightmap triangle sampler top level: height store, query sequencer, output register.
// Depends on hts_pkg and hts_ram.
//
// A write request stores one 16-bit height at cell_index; the block is ready again on
// the next cycle. A query request steps through MX, MZ, SETUP, RD1, RD2, RD3, MAC3 and
// SCALE to FIN, where the result is loaded into the output register (straight to FIN
// when no height has been written yet); a further query is taken the cycle after that
// load. The sequence uses one shared 33x33 multiplier three times in turn (x product, z
// product, vertical scale) and the three corner reads that go one per cycle through the
// single port of the height RAM. The result waits in its own register, so a write or the
// next query may be accepted while the result is still stalled. The store has no reset
// and no clearing pass: entries read before being written give undefined heights.
// Configuration writes take effect at once and are meant for idle periods.
module heightmap_triangle_sampler (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [hts_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [hts_pkg::Q_W-1:0]             cfg_data,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic                                op,
	input  logic [hts_pkg::IDX_W-1:0]           cell_index,
	input  logic signed [hts_pkg::HGT_W-1:0]    height_value,
	input  logic signed [hts_pkg::Q_W-1:0]      pos_x,
	input  logic signed [hts_pkg::Q_W-1:0]      pos_z,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic signed [hts_pkg::Q_W-1:0]      height,
	output logic                                undefined
);

	import hts_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MX,
		S_MZ,
		S_SETUP,
		S_RD1,
		S_RD2,
		S_RD3,
		S_MAC3,
		S_SCALE,
		S_FIN
	} state_t;

	state_t state_q;

	// configuration
	logic [Q_W-1:0]    ox_q, oz_q, isx_q, isz_q, hs_q, ho_q;
	logic [VCFG_W-1:0] vx_cfg_q, vz_cfg_q;

	logic has_data_q;
	logic nodata_q;
	logic undef_q;
	logic oob_q;

	// datapath
	logic [Q_W-1:0]      dx_q, dz_q;
	logic [Q_W-1:0]      cx_q;
	logic [FRAC_W-1:0]   fx_q;
	logic signed [65:0]  prod_q;
	logic [COORD_W-1:0]  cxa_q [3];
	logic [COORD_W-1:0]  cza_q [3];
	logic [WGT_W-1:0]    w_q [3];
	logic [VERTS_W-1:0]  vxe_q;
	logic signed [33:0]  acc_q;

	logic              res_valid_q;
	logic [Q_W-1:0]    height_q;
	logic              undefined_q;

	// Difference to the origin, clamped at zero (first cell, no fraction).
	function automatic logic [Q_W-1:0] grid_dist(input logic [Q_W-1:0] p,
		input logic [Q_W-1:0] o);
		logic [Q_W:0] d;
		d = {p[Q_W-1], p} - {o[Q_W-1], o};
		return (d[Q_W] || (d == '0)) ? '0 : d[Q_W-1:0];
	endfunction

	function automatic logic [VERTS_W-1:0] eff_verts(input logic [VCFG_W-1:0] v);
		if (v == '0) return VERTS_W'(1);
		if (32'(v) > GRID_SIDE) return VERTS_W'(GRID_SIDE);
		return VERTS_W'(v);
	endfunction

	function automatic logic [COORD_W-1:0] clamp0(input logic [Q_W-1:0] c,
		input logic [COORD_W-1:0] m);
		return (c >= Q_W'(m)) ? m : COORD_W'(c);
	endfunction

	function automatic logic [COORD_W-1:0] clamp1(input logic [Q_W-1:0] c,
		input logic [COORD_W-1:0] m);
		return (c >= Q_W'(m)) ? m : COORD_W'(c + 32'd1);
	endfunction

	// request handshake
	logic req_acc, wr_ok;
	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign wr_ok     = (32'(cell_index) < STORE_DEPTH);

	// corner address: one read per cycle in RD1..RD3, data back through the registered RAM output
	logic [1:0]       rd_k, mac_j;
	logic [LIN_W-1:0] lin;
	logic             rd_oob;
	logic             ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [HGT_W-1:0] ram_rdata;

	always_comb begin
		unique case (state_q)
			S_RD2: begin
				rd_k  = 2'd1;
				mac_j = 2'd0;
			end
			S_RD3: begin
				rd_k  = 2'd2;
				mac_j = 2'd1;
			end
			S_MAC3: begin
				rd_k  = 2'd0;
				mac_j = 2'd2;
			end
			default: begin
				rd_k  = 2'd0;
				mac_j = 2'd0;
			end
		endcase
	end

	assign lin = LIN_W'(cza_q[rd_k]) * LIN_W'(vxe_q) + LIN_W'(cxa_q[rd_k]);
	assign rd_oob = (32'(lin) >= STORE_DEPTH);

	assign ram_we   = req_acc && (op == OP_WRITE) && wr_ok;
	assign ram_addr = (state_q == S_IDLE) ? ADDR_W'(cell_index) : ADDR_W'(lin);

	hts_ram #(
		.WIDTH (HGT_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (height_value),
		.rdata (ram_rdata)
	);

	// corner blend: one corner product per cycle into the accumulator
	logic [HGT_W-1:0]   cv;
	logic               cv_undef;
	logic signed [33:0] mac_prod;

	assign cv       = oob_q ? '0 : ram_rdata;
	assign cv_undef = (cv == UNDEF_CODE);
	assign mac_prod = $signed(cv) * $signed({1'b0, w_q[mac_j]});

	// shared multiplier: x product, z product, then vertical scale
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;

	always_comb begin
		unique case (state_q)
			S_MX: begin
				mul_a = $signed({1'b0, dx_q});
				mul_b = $signed({1'b0, isx_q});
			end
			S_MZ: begin
				mul_a = $signed({1'b0, dz_q});
				mul_b = $signed({1'b0, isz_q});
			end
			default: begin
				mul_a = $signed({hs_q[Q_W-1], hs_q});
				mul_b = acc_q[32:0];
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// cell setup: clamping, triangle choice, barycentric weights
	logic [VERTS_W-1:0] vxe, vze;
	logic [COORD_W-1:0] vxm1, vzm1;
	logic [Q_W-1:0]     cz;
	logic [FRAC_W-1:0]  fz;
	logic [COORD_W-1:0] x0, x1, z0, z1;
	logic [WGT_W-1:0]   fsum;
	logic               upper;

	assign vxe   = eff_verts(vx_cfg_q);
	assign vze   = eff_verts(vz_cfg_q);
	assign vxm1  = COORD_W'(vxe - VERTS_W'(1));
	assign vzm1  = COORD_W'(vze - VERTS_W'(1));
	assign cz    = prod_q[63:32];
	assign fz    = prod_q[31:16];
	assign x0    = clamp0(cx_q, vxm1);
	assign x1    = clamp1(cx_q, vxm1);
	assign z0    = clamp0(cz, vzm1);
	assign z1    = clamp1(cz, vzm1);
	assign fsum  = {1'b0, fx_q} + {1'b0, fz};
	assign upper = (fsum >= ONE_Q16);

	// final: floor shift, offset, saturation
	logic signed [49:0] scaled;
	logic signed [50:0] sum;
	logic [Q_W-1:0]     sat;

	assign scaled = prod_q[65:16];
	assign sum    = {scaled[49], scaled} + {{19{ho_q[Q_W-1]}}, ho_q};

	always_comb begin
		if ((sum[50:31] == '0) || (sum[50:31] == '1)) begin
			sat = sum[31:0];
		end else if (sum[50]) begin
			sat = Q_MIN;
		end else begin
			sat = Q_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ox_q        <= '0;
			oz_q        <= '0;
			isx_q       <= Q_W'(ONE_Q16);
			isz_q       <= Q_W'(ONE_Q16);
			vx_cfg_q    <= VCFG_W'(128);
			vz_cfg_q    <= VCFG_W'(128);
			hs_q        <= Q_W'(ONE_Q16);
			ho_q        <= '0;
			has_data_q  <= 1'b0;
			nodata_q    <= 1'b0;
			undef_q     <= 1'b0;
			oob_q       <= 1'b0;
			res_valid_q <= 1'b0;
			undefined_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					CFG_ORIGIN_X:      ox_q     <= cfg_data;
					CFG_ORIGIN_Z:      oz_q     <= cfg_data;
					CFG_INV_SPACING_X: isx_q    <= cfg_data;
					CFG_INV_SPACING_Z: isz_q    <= cfg_data;
					CFG_VERTS_X:       vx_cfg_q <= cfg_data[VCFG_W-1:0];
					CFG_VERTS_Z:       vz_cfg_q <= cfg_data[VCFG_W-1:0];
					CFG_HEIGHT_SCALE:  hs_q     <= cfg_data;
					CFG_HEIGHT_OFFSET: ho_q     <= cfg_data;
					default: ;
				endcase
			end

			// in S_FIN the load below owns the valid flag
			if (res_valid_q && !res_stall && (state_q != S_FIN)) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						if (op == OP_WRITE) begin
							if (wr_ok) begin
								has_data_q <= 1'b1;
							end
						end else begin
							dx_q     <= grid_dist(pos_x, ox_q);
							dz_q     <= grid_dist(pos_z, oz_q);
							undef_q  <= 1'b0;
							nodata_q <= !has_data_q;
							state_q  <= has_data_q ? S_MX : S_FIN;
						end
					end
				end
				S_MX: begin
					prod_q  <= mul_p;
					state_q <= S_MZ;
				end
				S_MZ: begin
					cx_q    <= prod_q[63:32];
					fx_q    <= prod_q[31:16];
					prod_q  <= mul_p;
					state_q <= S_SETUP;
				end
				S_SETUP: begin
					if (upper) begin
						// upper triangle: (x+1,z+1), (x,z+1), (x+1,z)
						cxa_q[0] <= x1;
						cza_q[0] <= z1;
						cxa_q[1] <= x0;
						cza_q[1] <= z1;
						cxa_q[2] <= x1;
						cza_q[2] <= z0;
						w_q[0]   <= fsum - ONE_Q16;
						w_q[1]   <= ONE_Q16 - {1'b0, fx_q};
						w_q[2]   <= ONE_Q16 - {1'b0, fz};
					end else begin
						cxa_q[0] <= x0;
						cza_q[0] <= z0;
						cxa_q[1] <= x1;
						cza_q[1] <= z0;
						cxa_q[2] <= x0;
						cza_q[2] <= z1;
						w_q[0]   <= ONE_Q16 - fsum;
						w_q[1]   <= {1'b0, fx_q};
						w_q[2]   <= {1'b0, fz};
					end
					vxe_q   <= vxe;
					acc_q   <= '0;
					state_q <= S_RD1;
				end
				S_RD1: begin
					oob_q   <= rd_oob;
					state_q <= S_RD2;
				end
				S_RD2: begin
					oob_q   <= rd_oob;
					acc_q   <= acc_q + mac_prod;
					undef_q <= undef_q || cv_undef;
					state_q <= S_RD3;
				end
				S_RD3: begin
					oob_q   <= rd_oob;
					acc_q   <= acc_q + mac_prod;
					undef_q <= undef_q || cv_undef;
					state_q <= S_MAC3;
				end
				S_MAC3: begin
					acc_q   <= acc_q + mac_prod;
					undef_q <= undef_q || cv_undef;
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					prod_q  <= mul_p;
					state_q <= S_FIN;
				end
				S_FIN: begin
					// hold here until the output register is free
					if (!res_valid_q || !res_stall) begin
						res_valid_q <= 1'b1;
						if (nodata_q) begin
							height_q <= '0;
						end else if (undef_q) begin
							height_q <= RES_UNDEF;
						end else begin
							height_q <= sat;
						end
						undefined_q <= !nodata_q && undef_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign height    = height_q;
	assign undefined = undefined_q;

endmodule

>>> src/hts_ram.sv
// Generic single-port synchronous RAM, read-first, with a registered read output.
// No dependencies.
module hts_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

>>> src/hts_checker.sv
// Port-level checker for the heightmap triangle sampler, with its bind.
// Depends on hts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hts_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   req_valid,
	input logic                   req_stall,
	input logic                   op,
	input logic                   res_valid,
	input logic                   res_stall,
	input logic [hts_pkg::Q_W-1:0] height,
	input logic                   undefined
);

	import hts_pkg::*;

	`HTS_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(height) && $stable(undefined), "stalled result changed")
	`HTS_ASSERT_IMP(a_undef_code, clk, arst_n, res_valid && undefined, height == RES_UNDEF, "undefined result without marker height")
	`HTS_ASSERT_NXT(a_query_busy, clk, arst_n, req_valid && !req_stall && (op == OP_QUERY), req_stall, "query accepted without going busy")
	`HTS_ASSERT_NXT(a_write_free, clk, arst_n, req_valid && !req_stall && (op == OP_WRITE), !req_stall, "write request left block busy")
	`HTS_ASSERT_IMP(a_res_from_query, clk, arst_n, $rose(res_valid), $past(req_stall), "result appeared with no query in flight")

endmodule

bind heightmap_triangle_sampler hts_checker u_hts_checker (.*);
